>>> rtl/edt_pkg.sv
// Shared types, constants and the day-division step function for the datetime converter.
package edt_pkg;

    // 86,400,000 ms per day = 84375 * 2^10; the low 10 bits bypass the divider
    localparam logic [17:0] DAY_DIVISOR   = 18'd84375;
    localparam int          DAY_STEPS_MAX = 6;

    // Divider state: partial remainder, dividend bits still to shift in with
    // quotient bits entering at the bottom, and the untouched low ms bits.
    typedef struct packed {
        logic [16:0] rem;
        logic [21:0] nq;
        logic [9:0]  lo;
    } day_div_t;

    // Run n restoring steps of the day division (n <= DAY_STEPS_MAX).
    function automatic day_div_t day_steps(day_div_t s, int n);
        day_div_t    r;
        logic [17:0] part;
        logic        ge;
        r = s;
        for (int i = 0; i < DAY_STEPS_MAX; i++) begin
            if (i < n) begin
                part = {r.rem, r.nq[21]};
                ge   = (part >= DAY_DIVISOR);
                if (ge) begin
                    part = part - DAY_DIVISOR;
                end
                r.nq  = {r.nq[20:0], ge};
                r.rem = part[16:0];
            end
        end
        return r;
    endfunction

endpackage

>>> rtl/edt_day_div.sv
// Four-stage pipelined division of the millisecond count into day number and ms of day.
module edt_day_div
    import edt_pkg::*;
(
    input  logic        clk,
    input  logic [3:0]  ld,
    input  logic [48:0] t,
    output logic [21:0] days,
    output logic [26:0] ms_of_day
);

    day_div_t head;
    day_div_t stg_reg [4];

    // The top 17 bits of t are always below the divisor, so they seed the remainder.
    assign head = day_div_t'(t);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            stg_reg[0] <= day_steps(head, 6);
        end
        if (ld[1])
        begin
            stg_reg[1] <= day_steps(stg_reg[0], 6);
        end
        if (ld[2])
        begin
            stg_reg[2] <= day_steps(stg_reg[1], 5);
        end
        if (ld[3])
        begin
            stg_reg[3] <= day_steps(stg_reg[2], 5);
        end
    end

    assign days      = stg_reg[3].nq;
    assign ms_of_day = {stg_reg[3].rem, stg_reg[3].lo};

endmodule

>>> rtl/epoch_ms_to_civil_datetime.sv
// Throughput: one beat per cycle while the output is not stalled; stages advance
// independently, so bubbles close up and a stalled output holds while earlier
// stages keep filling.
// Depth is set by the 22-step day division (four stages) and the era/year/month chain.
// Reset clears all stage valid bits and sets the hour offset to 0.
module epoch_ms_to_civil_datetime
    import edt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] epoch_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [13:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  second,
    output logic [9:0]  millisecond
);

    localparam int NSTG = 12;

    localparam logic [26:0] MS_PER_HOUR    = 27'd3600000;
    localparam logic [21:0] MS_PER_MIN     = 22'd60000;
    localparam logic [15:0] MS_PER_SEC     = 16'd1000;
    localparam logic [21:0] MARCH_SHIFT    = 22'd719468;
    localparam logic [21:0] ERA_DAYS       = 22'd146097;
    localparam logic [17:0] FOUR_YEAR_DAYS = 18'd1460;
    localparam logic [17:0] CENTURY_DAYS   = 18'd36524;
    localparam logic [17:0] ERA_LAST_DAY   = 18'd146096;
    localparam logic [17:0] YEAR_DAYS      = 18'd365;
    localparam logic [12:0] YEAR_DAYS_13   = 13'd365;
    localparam logic [8:0]  CENTURY_YEARS  = 9'd100;
    localparam logic [13:0] ERA_YEARS      = 14'd400;
    localparam logic [10:0] MONTH_SPAN     = 11'd153;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [9:0] ms;
    } tod_t;

    // Days from March 1 to the start of each March-based month: (153*mp+2)/5
    function automatic logic [8:0] month_start(logic [3:0] mp);
        logic [8:0] v;
        case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Handshake and valid tracking
    logic [NSTG:1] valid_reg;
    logic [NSTG:1] valid_next;
    logic [NSTG:1] vin;
    logic [NSTG:1] rdy;
    logic [4:0]    tz_reg;

    // Stage 1
    logic [26:0] tz_ms;
    logic [48:0] t_next;
    logic [48:0] t_reg;

    // Stages 2-5
    logic [21:0] days;
    logic [26:0] ms_of_day;

    // Stage 6
    logic [21:0] z;
    logic [4:0]  era_next;
    logic [26:0] hr_r;
    logic [4:0]  hour_next;
    logic        ge6;
    logic [4:0]  era6_reg;
    logic [17:0] doe6_reg;
    logic [4:0]  hour6_reg;
    logic [21:0] remh6_reg;

    // Stage 7
    logic [17:0] c1_r;
    logic [6:0]  c1;
    logic [17:0] c2_r;
    logic [2:0]  c2;
    logic        c3;
    logic [17:0] numer_next;
    logic [21:0] mi_r;
    logic [5:0]  minute_next;
    logic        ge7;
    logic [4:0]  era7_reg;
    logic [17:0] doe7_reg;
    logic [17:0] numer7_reg;
    logic [4:0]  hour7_reg;
    logic [5:0]  minute7_reg;
    logic [15:0] remm7_reg;

    // Stage 8
    logic [17:0] yh_r;
    logic [4:0]  yhi_next;
    logic [15:0] se_r;
    logic [5:0]  second_next;
    logic        ge8;
    logic [4:0]  era8_reg;
    logic [17:0] doe8_reg;
    logic [4:0]  yhi8_reg;
    logic [12:0] yrem8_reg;
    tod_t        tod8_reg;

    // Stage 9
    logic [12:0] yl_r;
    logic [3:0]  ylo_next;
    logic        ge9;
    logic [4:0]  era9_reg;
    logic [17:0] doe9_reg;
    logic [8:0]  yoe9_reg;
    tod_t        tod9_reg;

    // Stage 10
    logic [8:0]  cy_r;
    logic [1:0]  c100;
    logic [17:0] doy_full;
    logic [13:0] ybase_next;
    logic        ge10;
    logic [8:0]  doy10_reg;
    logic [13:0] ybase10_reg;
    tod_t        tod10_reg;

    // Stage 11
    logic [10:0] mp_r;
    logic [3:0]  mp_next;
    logic        ge11;
    logic [3:0]  mp11_reg;
    logic [8:0]  doy11_reg;
    logic [13:0] ybase11_reg;
    tod_t        tod11_reg;

    // Stage 12 (output)
    logic [8:0]  dd;
    logic [3:0]  mon_next;
    logic [13:0] year_next;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;
    tod_t        tod12_reg;

    // A stage takes a new beat when it is empty or the stage after it moves.
    assign vin = {valid_reg[NSTG-1:1], in_valid};

    always_comb
    begin
        rdy[NSTG] = !valid_reg[NSTG] || !out_stall;
        for (int k = NSTG - 1; k >= 1; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
        valid_next = (rdy & vin) | (~rdy & valid_reg);
    end

    assign in_stall  = !rdy[1];
    assign out_valid = valid_reg[NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            tz_reg    <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr_en)
            begin
                tz_reg <= cfg_wr_data;
            end
        end
    end

    // Stage 1: apply the hour offset
    assign tz_ms  = tz_reg * MS_PER_HOUR;
    assign t_next = {1'b0, epoch_ms} + {22'd0, tz_ms};

    // Stages 2-5: day number and ms of day
    edt_day_div u_day_div (
        .clk       (clk),
        .ld        (rdy[5:2]),
        .t         (t_reg),
        .days      (days),
        .ms_of_day (ms_of_day)
    );

    // Stage 6: 400-year era and hour of day
    always_comb
    begin
        z        = days + MARCH_SHIFT;
        era_next = '0;
        for (int k = 4; k >= 0; k--)
        begin
            ge6 = (z >= (ERA_DAYS << k));
            if (ge6)
            begin
                z = z - (ERA_DAYS << k);
            end
            era_next = {era_next[3:0], ge6};
        end
        hr_r      = ms_of_day;
        hour_next = '0;
        for (int k = 4; k >= 0; k--)
        begin
            ge6 = (hr_r >= (MS_PER_HOUR << k));
            if (ge6)
            begin
                hr_r = hr_r - (MS_PER_HOUR << k);
            end
            hour_next = {hour_next[3:0], ge6};
        end
    end

    // Stage 7: leap corrections within the era, minute
    always_comb
    begin
        c1_r = doe6_reg;
        c1   = '0;
        for (int k = 6; k >= 0; k--)
        begin
            ge7 = (c1_r >= (FOUR_YEAR_DAYS << k));
            if (ge7)
            begin
                c1_r = c1_r - (FOUR_YEAR_DAYS << k);
            end
            c1 = {c1[5:0], ge7};
        end
        c2_r = doe6_reg;
        c2   = '0;
        for (int k = 2; k >= 0; k--)
        begin
            ge7 = (c2_r >= (CENTURY_DAYS << k));
            if (ge7)
            begin
                c2_r = c2_r - (CENTURY_DAYS << k);
            end
            c2 = {c2[1:0], ge7};
        end
        c3         = (doe6_reg == ERA_LAST_DAY);
        numer_next = doe6_reg - {11'd0, c1} + {15'd0, c2} - {17'd0, c3};
        mi_r        = remh6_reg;
        minute_next = '0;
        for (int k = 5; k >= 0; k--)
        begin
            ge7 = (mi_r >= (MS_PER_MIN << k));
            if (ge7)
            begin
                mi_r = mi_r - (MS_PER_MIN << k);
            end
            minute_next = {minute_next[4:0], ge7};
        end
    end

    // Stage 8: upper year-of-era bits, second and millisecond
    always_comb
    begin
        yh_r     = numer7_reg;
        yhi_next = '0;
        for (int k = 8; k >= 4; k--)
        begin
            ge8 = (yh_r >= (YEAR_DAYS << k));
            if (ge8)
            begin
                yh_r = yh_r - (YEAR_DAYS << k);
            end
            yhi_next = {yhi_next[3:0], ge8};
        end
        se_r        = remm7_reg;
        second_next = '0;
        for (int k = 5; k >= 0; k--)
        begin
            ge8 = (se_r >= (MS_PER_SEC << k));
            if (ge8)
            begin
                se_r = se_r - (MS_PER_SEC << k);
            end
            second_next = {second_next[4:0], ge8};
        end
    end

    // Stage 9: lower year-of-era bits
    always_comb
    begin
        yl_r     = yrem8_reg;
        ylo_next = '0;
        for (int k = 3; k >= 0; k--)
        begin
            ge9 = (yl_r >= (YEAR_DAYS_13 << k));
            if (ge9)
            begin
                yl_r = yl_r - (YEAR_DAYS_13 << k);
            end
            ylo_next = {ylo_next[2:0], ge9};
        end
    end

    // Stage 10: day of the March-based year, base year
    always_comb
    begin
        cy_r = yoe9_reg;
        c100 = '0;
        for (int k = 1; k >= 0; k--)
        begin
            ge10 = (cy_r >= (CENTURY_YEARS << k));
            if (ge10)
            begin
                cy_r = cy_r - (CENTURY_YEARS << k);
            end
            c100 = {c100[0], ge10};
        end
        doy_full   = doe9_reg - ({9'd0, yoe9_reg} * YEAR_DAYS)
                   - {11'd0, yoe9_reg[8:2]} + {16'd0, c100};
        ybase_next = ({9'd0, era9_reg} * ERA_YEARS) + {5'd0, yoe9_reg};
    end

    // Stage 11: March-based month
    always_comb
    begin
        mp_r    = ({2'd0, doy10_reg} * 11'd5) + 11'd2;
        mp_next = '0;
        for (int k = 3; k >= 0; k--)
        begin
            ge11 = (mp_r >= (MONTH_SPAN << k));
            if (ge11)
            begin
                mp_r = mp_r - (MONTH_SPAN << k);
            end
            mp_next = {mp_next[2:0], ge11};
        end
    end

    // Stage 12: day of month, January-based month, year
    always_comb
    begin
        dd        = doy11_reg - month_start(mp11_reg) + 9'd1;
        mon_next  = (mp11_reg < 4'd10) ? mp11_reg + 4'd3 : mp11_reg - 4'd9;
        year_next = ybase11_reg + {13'd0, (mon_next <= 4'd2)};
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            t_reg <= t_next;
        end
        if (rdy[6])
        begin
            era6_reg  <= era_next;
            doe6_reg  <= z[17:0];
            hour6_reg <= hour_next;
            remh6_reg <= hr_r[21:0];
        end
        if (rdy[7])
        begin
            era7_reg    <= era6_reg;
            doe7_reg    <= doe6_reg;
            numer7_reg  <= numer_next;
            hour7_reg   <= hour6_reg;
            minute7_reg <= minute_next;
            remm7_reg   <= mi_r[15:0];
        end
        if (rdy[8])
        begin
            era8_reg  <= era7_reg;
            doe8_reg  <= doe7_reg;
            yhi8_reg  <= yhi_next;
            yrem8_reg <= yh_r[12:0];
            tod8_reg  <= '{hour: hour7_reg, minute: minute7_reg,
                           second: second_next, ms: se_r[9:0]};
        end
        if (rdy[9])
        begin
            era9_reg <= era8_reg;
            doe9_reg <= doe8_reg;
            yoe9_reg <= {yhi8_reg, ylo_next};
            tod9_reg <= tod8_reg;
        end
        if (rdy[10])
        begin
            doy10_reg   <= doy_full[8:0];
            ybase10_reg <= ybase_next;
            tod10_reg   <= tod9_reg;
        end
        if (rdy[11])
        begin
            mp11_reg    <= mp_next;
            doy11_reg   <= doy10_reg;
            ybase11_reg <= ybase10_reg;
            tod11_reg   <= tod10_reg;
        end
        if (rdy[12])
        begin
            year_reg  <= year_next;
            month_reg <= mon_next;
            day_reg   <= dd[4:0];
            tod12_reg <= tod11_reg;
        end
    end

    assign year        = year_reg;
    assign month       = month_reg;
    assign day         = day_reg;
    assign hour        = tod12_reg.hour;
    assign minute      = tod12_reg.minute;
    assign second      = tod12_reg.second;
    assign millisecond = tod12_reg.ms;

endmodule

>>> tb/civil_datetime_checker.sv
// Checker for the datetime converter: predicts each output beat and compares it field by field.
module civil_datetime_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [47:0] epoch_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [13:0] year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    input  logic [9:0]  millisecond,
    output int          errors,
    output int          pending
);

    localparam longint unsigned MS_SECOND   = 64'd1000;
    localparam longint unsigned MS_MINUTE   = 64'd60000;
    localparam longint unsigned MS_HOUR     = 64'd3600000;
    localparam longint unsigned MS_DAY      = 64'd86400000;
    localparam longint unsigned MARCH_SHIFT = 64'd719468;
    localparam longint unsigned ERA_DAYS    = 64'd146097;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millisecond;
    } civil_stamp_t;

    civil_stamp_t stamps_due[$];
    logic [4:0]   offset_hours;

    // Shift to a March-based day count, split into 400-year eras, then year, day and month.
    function automatic civil_stamp_t civil_from_epoch(logic [47:0] stamp, logic [4:0] offs);
        longint unsigned t, days, rem, z, era, doe, yoe, doy, mp, d, m, y, hr, mi, s;
        civil_stamp_t    r;
        t    = {16'd0, stamp} + {59'd0, offs} * MS_HOUR;
        days = t / MS_DAY;
        rem  = t % MS_DAY;
        hr   = rem / MS_HOUR;
        rem  = rem % MS_HOUR;
        mi   = rem / MS_MINUTE;
        rem  = rem % MS_MINUTE;
        s    = rem / MS_SECOND;
        rem  = rem % MS_SECOND;
        z    = days + MARCH_SHIFT;
        era  = z / ERA_DAYS;
        doe  = z - era * ERA_DAYS;
        yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp   = (5 * doy + 2) / 153;
        d    = doy - (153 * mp + 2) / 5 + 1;
        m    = (mp < 10) ? mp + 3 : mp - 9;
        y    = yoe + era * 400 + ((m <= 2) ? 1 : 0);
        r.year        = y[13:0];
        r.month       = m[3:0];
        r.day         = d[4:0];
        r.hour        = hr[4:0];
        r.minute      = mi[5:0];
        r.second      = s[5:0];
        r.millisecond = rem[9:0];
        return r;
    endfunction

    function automatic void check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        civil_stamp_t want;
        if (!rst_n) begin
            offset_hours = '0;
            stamps_due.delete();
            errors  = 0;
            pending = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                stamps_due.push_back(civil_from_epoch(epoch_ms, offset_hours));
            end
            if (out_valid && !out_stall) begin
                if (stamps_due.size() == 0) begin
                    $display("%0t: unexpected output beat: expected none, actual %0d-%0d-%0d",
                             $time, year, month, day);
                    errors++;
                end
                else begin
                    want = stamps_due.pop_front();
                    check_field("year", want.year, year);
                    check_field("month", want.month, month);
                    check_field("day", want.day, day);
                    check_field("hour", want.hour, hour);
                    check_field("minute", want.minute, minute);
                    check_field("second", want.second, second);
                    check_field("millisecond", want.millisecond, millisecond);
                end
            end
            if (cfg_wr_en) begin
                offset_hours = cfg_wr_data;
            end
            pending = stamps_due.size();
        end
    end

endmodule

>>> tb/tb_epoch_ms_to_civil_datetime.sv
// Top of the datetime converter testbench: clock, reset, stimulus, stall patterns and verdict.
module tb_epoch_ms_to_civil_datetime;

    localparam int          QUIET_LIMIT = 3000;
    localparam int          RX_HOLD     = 64;
    localparam int          BURST_BEATS = 150;
    localparam logic [47:0] STAMP_MAX   = 48'hFFFF_FFFF_FFFF;
    localparam longint unsigned MS_DAY  = 64'd86400000;

    localparam logic [47:0] CORNERS [14] = '{
        48'd0, 48'd1, 48'd999, 48'd86399999, 48'd86400000,
        48'd68169600000,   // leap day 1972
        48'd946684799999,  // last ms of 1999
        48'd951782400000,  // leap day 2000
        48'd951868800000,  // first day of an era
        48'd4107456000000, // Feb 28 of a non-leap century year
        48'd4107542400000,
        STAMP_MAX, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [4:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic [47:0] epoch_ms = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [9:0]  millisecond;

    int errors;
    int pending;
    int quiet_cycles = 0;
    bit tx_gaps = 1'b1;
    bit rx_gaps = 1'b1;
    bit rx_hold_go = 1'b0;

    epoch_ms_to_civil_datetime i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .epoch_ms    (epoch_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .millisecond (millisecond)
    );

    civil_datetime_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .epoch_ms    (epoch_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .year        (year),
        .month       (month),
        .day         (day),
        .hour        (hour),
        .minute      (minute),
        .second      (second),
        .millisecond (millisecond),
        .errors      (errors),
        .pending     (pending)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // Receiver: random stalls, or one long hold-off when asked for.
    initial begin
        forever begin
            @(posedge clk);
            if (rx_hold_go) begin
                out_stall <= 1'b1;
                repeat (RX_HOLD) @(posedge clk);
                out_stall  <= 1'b0;
                rx_hold_go = 1'b0;
            end
            else begin
                out_stall <= rx_gaps && ($urandom_range(99) < 35);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [47:0] pick_stamp();
        longint unsigned v;
        case ($urandom_range(4))
            0: v = {16'($urandom), 32'($urandom)};
            1: begin
                // land within two hours of a midnight
                v = longint'($urandom_range(3257811)) * MS_DAY;
                v = v + 64'd7200000 - $urandom_range(14400000);
            end
            2: v = {22'd0, 10'($urandom), 32'($urandom)};
            3: v = {32'd0, 32'($urandom)};
            default: v = STAMP_MAX - $urandom_range(32'h3FFF_FFFF);
        endcase
        return v[47:0];
    endfunction

    // Hold the beat until accepted; leaves valid high for the next beat.
    task automatic send_stamp(logic [47:0] stamp);
        while (tx_gaps && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        epoch_ms <= stamp;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    task automatic write_offset(logic [4:0] hours);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= hours;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (CORNERS[i]) begin
            send_stamp(CORNERS[i]);
        end
        drain();

        // offset past a day: hours roll into the next date
        write_offset(5'd31);
        send_stamp(48'd0);
        send_stamp(48'd82800000);
        send_stamp(48'd946684799999);
        send_stamp(STAMP_MAX);
        drain();
        write_offset(5'd23);
        send_stamp(48'd3600000);
        send_stamp(STAMP_MAX);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: write_offset(5'd0);
                1: write_offset(5'd31);
                2: write_offset(5'd23);
                default: write_offset(5'($urandom_range(31)));
            endcase
            tx_gaps = (ph != 4) && (ph != 6);
            rx_gaps = (ph != 4);
            if (ph == 6) begin
                rx_hold_go = 1'b1;
            end
            repeat (BURST_BEATS) begin
                send_stamp(pick_stamp());
            end
            drain();
        end

        repeat (24) @(posedge clk);
        if (errors == 0) begin
            $display("Verification passed");
        end
        else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
